[rtl/cyp_pkg.sv]
package cyp_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int TABLE_LEN    = 32;
  localparam int STEPS        = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  localparam int POS_W   = 32;
  localparam int TAG_W   = 32;
  localparam int YAW_W   = 25;
  localparam int PITCH_W = 24;

  // datapath: coordinates plus headroom for pre-rotation and cordic gain
  localparam int CW    = COORD_WIDTH + 3;
  localparam int MAG_W = CW - 1;
  localparam int AW    = 26;

  localparam int GAIN_FRAC = 30;
  localparam int SPLIT     = (MAG_W + 1) / 2;
  localparam int HI_W      = MAG_W - SPLIT;
  localparam int PHI_W     = HI_W + GAIN_FRAC;
  localparam int PLO_W     = SPLIT + GAIN_FRAC;
  localparam int SUM_W     = MAG_W + GAIN_FRAC + 1;

  localparam logic [GAIN_FRAC-1:0] INV_GAIN     = GAIN_FRAC'(652032874);
  localparam logic signed [AW-1:0] YAW_LIMIT    = AW'(11796480);
  localparam logic signed [AW-1:0] PITCH_LIMIT  = AW'(5898240);
  localparam logic signed [AW-1:0] QUARTER_TURN = AW'(5898240);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int SIGN_POS = (COORD_WIDTH <= POS_W) ? COORD_WIDTH - 1 : POS_W - 1;
  localparam bit SIGN_ON  = (COORD_WIDTH <= POS_W);

  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [AW-1:0]    ang;
    logic signed [CW-1:0]    z;
    logic [TAG_W-1:0]        tag;
    logic                    hzero;
  } cyp_work_t;

  typedef struct packed {
    logic signed [YAW_W-1:0] yaw;
    logic signed [CW-1:0]    z;
    logic [TAG_W-1:0]        tag;
    logic                    hold_zero;
  } cyp_side_t;

  function automatic logic signed [AW-1:0] atan_q16(input int idx);
    logic signed [AW-1:0] v;
    case (idx)
      0:  v = AW'(2949120);
      1:  v = AW'(1740967);
      2:  v = AW'(919879);
      3:  v = AW'(466945);
      4:  v = AW'(234379);
      5:  v = AW'(117304);
      6:  v = AW'(58666);
      7:  v = AW'(29335);
      8:  v = AW'(14668);
      9:  v = AW'(7334);
      10: v = AW'(3667);
      11: v = AW'(1833);
      12: v = AW'(917);
      13: v = AW'(458);
      14: v = AW'(229);
      15: v = AW'(115);
      16: v = AW'(57);
      17: v = AW'(29);
      18: v = AW'(14);
      19: v = AW'(7);
      20: v = AW'(4);
      21: v = AW'(2);
      22: v = AW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [CW-1:0] sext_coord(input logic [POS_W-1:0] raw);
    logic signed [CW-1:0] v;
    for (int i = 0; i < CW; i++) begin
      if (i < COORD_WIDTH) begin
        v[i] = (i < POS_W) ? raw[i % POS_W] : 1'b0;
      end else begin
        v[i] = SIGN_ON ? raw[SIGN_POS] : 1'b0;
      end
    end
    return v;
  endfunction

  function automatic logic signed [YAW_W-1:0] clamp_yaw(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] c;
    if (a > YAW_LIMIT) begin
      c = YAW_LIMIT;
    end else if (a < -YAW_LIMIT) begin
      c = -YAW_LIMIT;
    end else begin
      c = a;
    end
    return c[YAW_W-1:0];
  endfunction

  function automatic logic signed [PITCH_W-1:0] clamp_pitch(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] c;
    if (a > PITCH_LIMIT) begin
      c = PITCH_LIMIT;
    end else if (a < -PITCH_LIMIT) begin
      c = -PITCH_LIMIT;
    end else begin
      c = a;
    end
    return c[PITCH_W-1:0];
  endfunction

endpackage

[rtl/cyp_in_if.sv]
interface cyp_in_if import cyp_pkg::*;;
  logic             valid;
  logic             ready;
  logic             tracking_valid;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [TAG_W-1:0] time_tag;

  modport source (output valid, tracking_valid, pos_x, pos_y, pos_z, time_tag,
                  input ready);
  modport sink   (input valid, tracking_valid, pos_x, pos_y, pos_z, time_tag,
                  output ready);
endinterface

[rtl/cyp_out_if.sv]
interface cyp_out_if import cyp_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [YAW_W-1:0]   yaw_angle;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic [TAG_W-1:0]          time_tag_out;

  modport source (output valid, yaw_angle, pitch_angle, time_tag_out, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, time_tag_out, output ready);
endinterface

[rtl/cyp_front.sv]
module cyp_front import cyp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  cyp_in_if.sink      in_chan,
  input  logic        pop,
  output logic        q_valid,
  output cyp_work_t   q_head
);

  cyp_work_t            work;
  cyp_work_t            q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 push;
  logic signed [CW-1:0] px, py;

  // quadrant pre-rotation and zero detection
  always_comb begin
    px = sext_coord(in_chan.pos_x);
    py = sext_coord(in_chan.pos_y);
    work.z     = sext_coord(in_chan.pos_z);
    work.tag   = in_chan.time_tag;
    work.hzero = (px == '0) && (py == '0);
    if (px[CW-1] && !py[CW-1]) begin
      work.x   = py;
      work.y   = -px;
      work.ang = QUARTER_TURN;
    end else if (px[CW-1]) begin
      work.x   = -py;
      work.y   = px;
      work.ang = -QUARTER_TURN;
    end else begin
      work.x   = px;
      work.y   = py;
      work.ang = '0;
    end
  end

  assign in_chan.ready = rst_n && (cnt_r != Q_CNT_W'(Q_DEPTH));
  // transactions with tracking clear are taken and dropped here
  assign push    = in_chan.valid && in_chan.ready && in_chan.tracking_valid;
  assign q_valid = (cnt_r != '0);
  assign q_head  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = (pop && q_valid) ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= work;
    end
  end

endmodule

[rtl/cyp_vector.sv]
module cyp_vector import cyp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic signed [AW-1:0] in_ang,
  input  cyp_side_t            in_side,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_x,
  output logic signed [AW-1:0] out_ang,
  output cyp_side_t            out_side
);

  logic                 valid_r [STEPS];
  logic signed [CW-1:0] x_r     [STEPS];
  logic signed [CW-1:0] y_r     [STEPS];
  logic signed [AW-1:0] ang_r   [STEPS];
  cyp_side_t            side_r  [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic                 pv;
    logic signed [CW-1:0] px, py, x_nxt, y_nxt;
    logic signed [AW-1:0] pa, ang_nxt;
    cyp_side_t            ps;

    if (i == 0) begin : g_first
      assign pv = in_valid;
      assign px = in_x;
      assign py = in_y;
      assign pa = in_ang;
      assign ps = in_side;
    end else begin : g_next
      assign pv = valid_r[i-1];
      assign px = x_r[i-1];
      assign py = y_r[i-1];
      assign pa = ang_r[i-1];
      assign ps = side_r[i-1];
    end

    // one micro-rotation toward y = 0
    always_comb begin
      if (!py[CW-1]) begin
        x_nxt   = px + (py >>> i);
        y_nxt   = py - (px >>> i);
        ang_nxt = pa + atan_q16(i);
      end else begin
        x_nxt   = px - (py >>> i);
        y_nxt   = py + (px >>> i);
        ang_nxt = pa - atan_q16(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        ang_r[i]  <= ang_nxt;
        side_r[i] <= ps;
      end
    end
  end

  assign out_valid = valid_r[STEPS-1];
  assign out_x     = x_r[STEPS-1];
  assign out_ang   = ang_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

[rtl/cyp_back.sv]
module cyp_back import cyp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cyp_work_t   q_head,
  output logic        pop,
  cyp_out_if.source   out_chan
);

  logic                 en;
  cyp_side_t            yaw_side_in, yaw_side, pitch_side_in, pitch_side;
  logic                 yv_valid, pv_valid;
  logic signed [CW-1:0] yv_mag, pv_mag;
  logic signed [AW-1:0] yv_ang, pv_ang;

  logic [MAG_W-1:0]     m;
  logic [SUM_W-1:0]     sum;

  logic                 g1_valid_r;
  logic [PHI_W-1:0]     g1_phi_r, g1_phi_nxt;
  logic [PLO_W-1:0]     g1_plo_r, g1_plo_nxt;
  cyp_side_t            g1_side_r, g1_side_nxt;

  logic                 g2_valid_r;
  logic signed [CW-1:0] g2_range_r, g2_range_nxt;
  cyp_side_t            g2_side_r, g2_side_nxt;

  logic                      out_valid_r;
  logic signed [YAW_W-1:0]   out_yaw_r;
  logic signed [PITCH_W-1:0] out_pitch_r, out_pitch_nxt;
  logic [TAG_W-1:0]          out_tag_r;

  // whole back pipeline advances when the output register can move
  assign en  = !out_valid_r || out_chan.ready;
  assign pop = en && q_valid;

  always_comb begin
    yaw_side_in           = '0;
    yaw_side_in.z         = q_head.z;
    yaw_side_in.tag       = q_head.tag;
    yaw_side_in.hold_zero = q_head.hzero;
  end

  cyp_vector u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (q_valid),
    .in_x      (q_head.x),
    .in_y      (q_head.y),
    .in_ang    (q_head.ang),
    .in_side   (yaw_side_in),
    .out_valid (yv_valid),
    .out_x     (yv_mag),
    .out_ang   (yv_ang),
    .out_side  (yaw_side)
  );

  // gain correction, split into two narrow products
  always_comb begin
    m = (yaw_side.hold_zero || yv_mag[CW-1]) ? '0 : yv_mag[MAG_W-1:0];
    g1_phi_nxt = PHI_W'(m[MAG_W-1:SPLIT]) * PHI_W'(INV_GAIN);
    g1_plo_nxt = PLO_W'(m[SPLIT-1:0]) * PLO_W'(INV_GAIN);
    g1_side_nxt     = yaw_side;
    g1_side_nxt.yaw = yaw_side.hold_zero ? '0 : clamp_yaw(yv_ang);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_phi_r  <= g1_phi_nxt;
      g1_plo_r  <= g1_plo_nxt;
      g1_side_r <= g1_side_nxt;
    end
  end

  always_comb begin
    sum          = (SUM_W'(g1_phi_r) << SPLIT) + SUM_W'(g1_plo_r);
    g2_range_nxt = CW'(sum[SUM_W-1:GAIN_FRAC]);
    g2_side_nxt           = g1_side_r;
    g2_side_nxt.hold_zero = (g2_range_nxt == '0) && (g1_side_r.z == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g2_range_r <= g2_range_nxt;
      g2_side_r  <= g2_side_nxt;
    end
  end

  assign pitch_side_in = g2_side_r;

  cyp_vector u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (g2_valid_r),
    .in_x      (g2_range_r),
    .in_y      (g2_side_r.z),
    .in_ang    ('0),
    .in_side   (pitch_side_in),
    .out_valid (pv_valid),
    .out_x     (pv_mag),
    .out_ang   (pv_ang),
    .out_side  (pitch_side)
  );

  assign out_pitch_nxt = pitch_side.hold_zero ? '0 : clamp_pitch(-pv_ang);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_valid_r  <= 1'b0;
      g2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      g1_valid_r  <= yv_valid;
      g2_valid_r  <= g1_valid_r;
      out_valid_r <= pv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_yaw_r   <= pitch_side.yaw;
      out_pitch_r <= out_pitch_nxt;
      out_tag_r   <= pitch_side.tag;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.yaw_angle    = out_yaw_r;
  assign out_chan.pitch_angle  = out_pitch_r;
  assign out_chan.time_tag_out = out_tag_r;

endmodule

[rtl/cartesian_to_yaw_pitch_unit.sv]
// Converts a target position (x, y, z, signed Q16.16) into yaw = atan2(y, x) and
// pitch = -atan2(z, horizontal range), both in degrees times 65536 and clamped to
// +-180 and +-90, with the time tag copied through. A transaction with tracking
// clear is accepted and yields no result. The block accepts one transaction per
// cycle and delivers one result per cycle while the receiver keeps ready high.
// Each result passes through two fully pipelined CORDIC vectoring chains, one
// micro-rotation per stage, with the gain-correction registers g1 and g2 between
// them and the output register at the end. A four-entry queue decouples the input
// from the compute pipeline; an accepted transaction is written into the queue and
// enters the first stage from its head when the back pipeline advances.
module cartesian_to_yaw_pitch_unit import cyp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cyp_in_if.sink    in_chan,
  cyp_out_if.source out_chan
);

  logic      q_valid;
  logic      pop;
  cyp_work_t q_head;

  cyp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .pop     (pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  cyp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
